/* sv/refcounted_address_table_top_assert.svh */
// assertion macros used by the checker file
`ifndef REFCOUNTED_ADDRESS_TABLE_TOP_ASSERT_SVH
`define REFCOUNTED_ADDRESS_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RAT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("refcounted address table: implication violated");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RAT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("refcounted address table: next-cycle implication violated");

`endif

/* sv/rat_pkg.sv */
package rat_pkg;

  // reference count width and its ceiling
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = 8'd254;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_EXISTING    = 3'd0,
    ST_NEW         = 3'd1,
    ST_FULL        = 3'd2,
    ST_DECREMENTED = 3'd3,
    ST_IGNORED     = 3'd4
  } rat_status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_ALLOC,
    S_REL,
    S_DONE
  } rat_state_t;

  // input item
  typedef struct packed {
    logic        command;
    logic [15:0] lookup_address;
    logic [5:0]  slot_index;
  } rat_in_t;

  // result item
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] result_slot;
    logic [7:0] count_after;
  } rat_out_t;

endpackage

/* sv/rat_cell.sv */
module rat_cell #(
  parameter int ADDR_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic [ADDR_BITS-1:0]      nbr_addr,
  input  logic [rat_pkg::CNT_W-1:0] nbr_cnt,
  output logic [ADDR_BITS-1:0]      cell_addr,
  output logic [rat_pkg::CNT_W-1:0] cell_cnt
);
  import rat_pkg::*;

  logic [ADDR_BITS-1:0] addr_r;
  logic [CNT_W-1:0]     cnt_r;

  // one table entry, takes its neighbor's entry when the ring turns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      cnt_r  <= '0;
    end else if (shift) begin
      addr_r <= nbr_addr;
      cnt_r  <= nbr_cnt;
    end
  end

  assign cell_addr = addr_r;
  assign cell_cnt  = cnt_r;

endmodule

/* sv/rat_ctrl.sv */
module rat_ctrl #(
  parameter int ENTRIES   = 64,
  parameter int ADDR_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rat_pkg::rat_in_t          in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rat_pkg::rat_out_t         out_item,
  input  logic [ADDR_BITS-1:0]      head_addr,
  input  logic [rat_pkg::CNT_W-1:0] head_cnt,
  output logic                      ring_shift,
  output logic [ADDR_BITS-1:0]      wb_addr,
  output logic [rat_pkg::CNT_W-1:0] wb_cnt
);
  import rat_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int LW    = (ADDR_BITS < 16) ? ADDR_BITS : 16;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  rat_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  logic                 found_r, found_nxt;
  rat_out_t             res_r, res_nxt;
  rat_out_t             out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_BITS-1:0] req_addr_r;
  logic [IDX_W-1:0]     req_idx_r;
  logic                 req_ok_r;

  logic accept;
  logic last;
  logic match_hit;
  logic free_hit;
  logic rel_hit;

  // handshake and scan position
  assign accept = in_valid && (state_r == S_IDLE);
  assign last   = (k_r == LAST_IDX);

  // per-cycle tests on the entry sitting at the head of the ring
  assign match_hit = (state_r == S_MATCH) && !found_r && (head_cnt != '0) &&
                     (head_cnt < COUNT_LIMIT) && (head_addr == req_addr_r);
  assign free_hit  = (state_r == S_ALLOC) && !found_r && (head_cnt == '0);
  assign rel_hit   = (state_r == S_REL) && req_ok_r && (k_r == req_idx_r) &&
                     (head_cnt != '0);

  // ring turns once per scan cycle
  assign ring_shift = (state_r == S_MATCH) || (state_r == S_ALLOC) ||
                      (state_r == S_REL);

  // updated head entry written back at the tail
  always_comb begin
    wb_addr = head_addr;
    wb_cnt  = head_cnt;
    if (match_hit) begin
      wb_cnt = head_cnt + CNT_W'(1);
    end
    if (free_hit) begin
      wb_addr = req_addr_r;
      wb_cnt  = CNT_W'(1);
    end
    if (rel_hit) begin
      wb_cnt = head_cnt - CNT_W'(1);
      if (head_cnt == CNT_W'(1)) begin
        wb_addr = '0;
      end
    end
  end

  // sequencer next state and result tracking
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt               = '0;
          found_nxt           = 1'b0;
          res_nxt.result_slot = '0;
          res_nxt.count_after = '0;
          if (in_item.command == CMD_FREE) begin
            res_nxt.status = ST_IGNORED;
            state_nxt      = S_REL;
          end else begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_MATCH;
          end
        end
      end
      S_MATCH: begin
        if (match_hit) begin
          found_nxt           = 1'b1;
          res_nxt.status      = ST_EXISTING;
          res_nxt.result_slot = 6'(k_r);
          res_nxt.count_after = head_cnt + CNT_W'(1);
        end
        k_nxt = last ? '0 : k_r + IDX_W'(1);
        if (last) begin
          state_nxt = (found_r || match_hit) ? S_DONE : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (free_hit) begin
          found_nxt           = 1'b1;
          res_nxt.status      = ST_NEW;
          res_nxt.result_slot = 6'(k_r);
          res_nxt.count_after = CNT_W'(1);
        end
        k_nxt = last ? '0 : k_r + IDX_W'(1);
        if (last) begin
          state_nxt = S_DONE;
        end
      end
      S_REL: begin
        if (rel_hit) begin
          found_nxt           = 1'b1;
          res_nxt.status      = ST_DECREMENTED;
          res_nxt.result_slot = 6'(k_r);
          res_nxt.count_after = head_cnt - CNT_W'(1);
        end
        k_nxt = last ? '0 : k_r + IDX_W'(1);
        if (last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
    if (accept) begin
      req_addr_r <= ADDR_BITS'(in_item.lookup_address[LW-1:0]);
      req_idx_r  <= IDX_W'(in_item.slot_index);
      req_ok_r   <= (32'(in_item.slot_index) < ENTRIES);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* sv/refcounted_address_table_top.sv */
// Reference-counted address intern table. The ENTRIES slots (address plus
// 8-bit count) live in a ring of cells that turns by one slot each cycle while
// a scan runs, past a single compare and update unit at its head. An item is
// accepted, the ring makes one full turn per scan, and the result then goes
// into the output register: free and an alloc of an address already held
// below count 254 each take one scan, and any other alloc (new slot or table
// full) takes two scans. One item is worked on at a time; a new item is taken
// while the previous result still waits on out_stall. Reset clears every slot
// at once.
module refcounted_address_table_top #(
  parameter int ENTRIES   = 64,
  parameter int ADDR_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rat_pkg::rat_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output rat_pkg::rat_out_t out_item
);
  import rat_pkg::*;

  logic [ADDR_BITS-1:0] cell_addr [ENTRIES];
  logic [CNT_W-1:0]     cell_cnt  [ENTRIES];
  logic                 ring_shift;
  logic [ADDR_BITS-1:0] wb_addr;
  logic [CNT_W-1:0]     wb_cnt;

  // sequencer at the ring head
  rat_ctrl #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .head_addr  (cell_addr[0]),
    .head_cnt   (cell_cnt[0]),
    .ring_shift (ring_shift),
    .wb_addr    (wb_addr),
    .wb_cnt     (wb_cnt)
  );

  // ring of slot cells, the last one takes the updated head entry
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_tail
      rat_cell #(
        .ADDR_BITS (ADDR_BITS)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (ring_shift),
        .nbr_addr  (wb_addr),
        .nbr_cnt   (wb_cnt),
        .cell_addr (cell_addr[i]),
        .cell_cnt  (cell_cnt[i])
      );
    end else begin : g_body
      rat_cell #(
        .ADDR_BITS (ADDR_BITS)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (ring_shift),
        .nbr_addr  (cell_addr[i+1]),
        .nbr_cnt   (cell_cnt[i+1]),
        .cell_addr (cell_addr[i]),
        .cell_cnt  (cell_cnt[i])
      );
    end
  end

endmodule

/* sv/rat_checker.sv */
`include "refcounted_address_table_top_assert.svh"

module rat_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input rat_pkg::rat_out_t out_item
);
  import rat_pkg::*;

  logic untouched;
  logic zero_item;
  logic counted;
  logic count_ok;

  // result kinds that touch no slot, and those that carry a live count
  assign untouched = (out_item.status == ST_FULL) || (out_item.status == ST_IGNORED);
  assign zero_item = (out_item.result_slot == 6'd0) && (out_item.count_after == 8'd0);
  assign counted   = (out_item.status == ST_NEW) || (out_item.status == ST_EXISTING);
  assign count_ok  = (out_item.count_after != 8'd0) && (out_item.count_after <= COUNT_LIMIT);

  // a stalled result item stays
  `RAT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `RAT_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_item))

  // status is always a known code
  `RAT_ASSERT_IMP(a_status_range, out_valid, out_item.status <= ST_IGNORED)

  // no slot touched means zero slot and zero count
  `RAT_ASSERT_IMP(a_untouched_zero, out_valid && untouched, zero_item)

  // fresh slot starts at one, a raised one is in range
  `RAT_ASSERT_IMP(a_count_sane, out_valid && counted, count_ok)

endmodule

bind refcounted_address_table_top rat_checker u_rat_checker (.*);
